[design/el2csr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// el2csr_pkg: shared constants for the edge list to CSR row index builder
// Default widths and the bit positions of the result flags in tuser.
// ----------------------------------------------------------------------------
package el2csr_pkg;

  localparam int VERTEX_BITS_DEF     = 32;
  localparam int EDGE_COUNT_BITS_DEF = 40;

  localparam int USER_BITS      = 2;
  localparam int USER_INDEX_BIT = 0;
  localparam int USER_ERROR_BIT = 1;

endpackage

[design/edge_list_to_csr_indexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_list_to_csr_indexer: CSR row index builder for a source-sorted edge stream
// Each accepted input beat yields one registered result beat.
// Throughput: one edge per cycle while s_tready is high; the running state (last source,
//   edge count, run start, id range, peak degree, gap total) updates on each accepted beat.
// A two-entry output buffer (result register plus skid register) keeps the
//   input side ready while one result waits downstream.
// Reset clears all running state; the lowest id returns to all ones.
// ----------------------------------------------------------------------------
module edge_list_to_csr_indexer
  import el2csr_pkg::*;
#(
  parameter int VERTEX_BITS     = VERTEX_BITS_DEF,
  parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF,
  localparam int IN_W  = ((2 * VERTEX_BITS + 7) / 8) * 8,
  localparam int RAW_W = 6 * VERTEX_BITS + 3 * EDGE_COUNT_BITS,
  localparam int OUT_W = ((RAW_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // src_vertex, dst_vertex
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // edge_position, edge_src, edge_dst, index_vertex, index_offset,
  // min_id, max_id, max_out_degree, gap_sum
  output logic [OUT_W-1:0]     m_tdata,
  // index_valid, order_error
  output logic [USER_BITS-1:0] m_tuser
);

  localparam int VB = VERTEX_BITS;
  localparam int EB = EDGE_COUNT_BITS;

  logic [VB-1:0] last_source, last_source_next;
  logic [EB-1:0] edge_count, edge_count_next;
  logic [EB-1:0] run_start, run_start_next;
  logic [VB-1:0] lowest_id, lowest_id_next;
  logic [VB-1:0] highest_id, highest_id_next;
  logic [EB-1:0] degree_peak, degree_peak_next;
  logic [VB-1:0] gap_total, gap_total_next;
  logic          error_seen, error_seen_next;

  logic [VB-1:0] src, dst;
  logic          bad, change;
  logic [EB-1:0] run_len;
  logic [EB-1:0] pos;
  logic [VB-1:0] osrc, odst, ivert;
  logic [EB-1:0] ioff;
  logic          ivalid;
  logic [RAW_W-1:0]     res_raw;
  logic [OUT_W-1:0]     res_data;
  logic [USER_BITS-1:0] res_user;

  logic                 skid_valid;
  logic [OUT_W-1:0]     skid_data;
  logic [USER_BITS-1:0] skid_user;
  logic                 in_fire;

  assign src     = s_tdata[VB-1:0];
  assign dst     = s_tdata[2*VB-1:VB];
  assign in_fire = s_tvalid && s_tready;
  assign s_tready = !skid_valid;

  assign bad     = error_seen || (src < last_source);
  assign change  = (src != last_source);
  assign run_len = edge_count - run_start;

  always_comb begin
    last_source_next = last_source;
    edge_count_next  = edge_count;
    run_start_next   = run_start;
    lowest_id_next   = lowest_id;
    highest_id_next  = highest_id;
    degree_peak_next = degree_peak;
    gap_total_next   = gap_total;
    error_seen_next  = error_seen;
    pos    = '0;
    osrc   = '0;
    odst   = '0;
    ivalid = 1'b0;
    ivert  = '0;
    ioff   = '0;
    if (bad) begin
      error_seen_next = 1'b1;
    end else begin
      if ((src < dst ? src : dst) < lowest_id) begin
        lowest_id_next = (src < dst) ? src : dst;
      end
      if ((src > dst ? src : dst) > highest_id) begin
        highest_id_next = (src > dst) ? src : dst;
      end
      pos  = edge_count;
      osrc = src;
      odst = dst;
      if (change) begin
        if (run_len > degree_peak) begin
          degree_peak_next = run_len;
        end
        run_start_next = edge_count;
        ivalid = 1'b1;
        ivert  = src;
        ioff   = edge_count;
        if (src != last_source + VB'(1)) begin
          gap_total_next = gap_total + (src - last_source);
        end
        last_source_next = src;
      end
      edge_count_next = edge_count + EB'(1);
    end
  end

  assign res_raw  = {gap_total_next, degree_peak_next, highest_id_next, lowest_id_next,
                     ioff, ivert, odst, osrc, pos};
  assign res_data = OUT_W'(res_raw);

  always_comb begin
    res_user = '0;
    res_user[USER_INDEX_BIT] = ivalid;
    res_user[USER_ERROR_BIT] = error_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_source <= '0;
      edge_count  <= '0;
      run_start   <= '0;
      lowest_id   <= '1;
      highest_id  <= '0;
      degree_peak <= '0;
      gap_total   <= '0;
      error_seen  <= 1'b0;
    end else if (in_fire) begin
      last_source <= last_source_next;
      edge_count  <= edge_count_next;
      run_start   <= run_start_next;
      lowest_id   <= lowest_id_next;
      highest_id  <= highest_id_next;
      degree_peak <= degree_peak_next;
      gap_total   <= gap_total_next;
      error_seen  <= error_seen_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= in_fire;
        end else begin
          m_tvalid <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else if (in_fire) begin
        m_tdata <= res_data;
        m_tuser <= res_user;
      end
    end
    if (in_fire && !(!skid_valid && (!m_tvalid || m_tready))) begin
      skid_data <= res_data;
      skid_user <= res_user;
    end
  end

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held without a pending result");

  a_error_sticky : assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen)
    else $error("order error cleared without reset");

  a_index_at_position : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_INDEX_BIT]) |->
      (m_tdata[2*EB+3*VB-1:EB+3*VB] == m_tdata[EB-1:0]))
    else $error("index offset differs from edge position");

  a_error_no_index : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_ERROR_BIT]) |->
      (!m_tuser[USER_INDEX_BIT] && m_tdata[EB-1:0] == '0))
    else $error("flagged beat carries edge data");

endmodule
